// ===== design/avz_pkg.sv =====
// package for the velocity estimator: widths, register indexes, config layout
// no dependencies
`timescale 1ns / 1ps
package avz_pkg;
  localparam int BiasLen = 16;
  localparam int BcW = 5;
  localparam int FW = 18;
  localparam int VW = 17;

  localparam logic [2:0] RegLowpass  = 3'd0;
  localparam logic [2:0] RegGravity  = 3'd1;
  localparam logic [2:0] RegThresh   = 3'd2;
  localparam logic [2:0] RegFrames   = 3'd3;
  localparam logic [2:0] RegDecay    = 3'd4;
  localparam logic [2:0] RegBoot     = 3'd5;
  localparam logic [2:0] RegLimit    = 3'd6;

  typedef struct packed {
    logic [3:0]  lowpass_shift;
    logic [12:0] gravity_ref;
    logic [11:0] rest_threshold;
    logic [7:0]  rest_frames_needed;
    logic [3:0]  decay_shift;
    logic [15:0] boot_wait_frames;
    logic [14:0] velocity_limit;
  } cfg_t;

  // arithmetic right shift, floor rounding
  function automatic logic signed [FW:0] sra_f(input logic signed [FW:0] x,
                                                input logic [3:0] s);
    sra_f = x >>> s;
  endfunction
endpackage

// ===== design/avz_sqrt.sv =====
// bit-serial integer square root, two radicand bits per cycle
// depends on avz_pkg
`timescale 1ns / 1ps
module avz_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] radicand,
  output logic        done,
  output logic [15:0] root
);
  import avz_pkg::*;

  logic [31:0] rad;
  logic [17:0] rem;
  logic [4:0]  cnt;
  logic        busy;
  logic [17:0] trial;
  logic [17:0] rem_sh;

  // restoring step: shift in two bits, try subtract 4r+1
  always_comb begin
    rem_sh = {rem[15:0], rad[31:30]};
    trial  = rem_sh - {root, 2'b01};
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 5'd0;
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[29:0], 2'b00};
      if (!trial[17]) begin
        rem  <= trial;
        root <= {root[14:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[14:0], 1'b0};
      end
      cnt <= cnt + 5'd1;
      if (cnt == 5'd15) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

// ===== design/avz_div.sv =====
// serial signed divider, truncating toward zero, one quotient bit per cycle
// depends on avz_pkg
`timescale 1ns / 1ps
module avz_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [avz_pkg::FW:0]   num,
  input  logic [avz_pkg::BcW-1:0]       den,
  output logic                          done,
  output logic signed [avz_pkg::FW:0]   quo
);
  import avz_pkg::*;

  localparam int NW = FW + 1;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0]   mag;
  logic [BcW:0]    rem;
  logic [NW-1:0]   q;
  logic            neg;
  logic [CW-1:0]   cnt;
  logic            busy;
  logic [BcW:0]    rem_sh;
  logic [BcW:0]    diff;

  always_comb begin
    rem_sh = {rem[BcW-1:0], mag[NW-1]};
    diff   = rem_sh - {1'b0, den};
    quo    = neg ? -$signed(q) : $signed(q);
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      neg  <= num[FW];
      mag  <= num[FW] ? NW'(-num) : NW'(num);
      rem  <= '0;
      q    <= '0;
      cnt  <= '0;
    end else if (busy) begin
      mag <= {mag[NW-2:0], 1'b0};
      if (rem_sh >= {1'b0, den}) begin
        rem <= diff;
        q   <= {q[NW-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        q   <= {q[NW-2:0], 1'b0};
      end
      cnt <= cnt + CW'(1);
      if (cnt == CW'(NW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

// ===== design/accel_velocity_zupt_estimator.sv =====
// top level of the accelerometer velocity estimator with rest detection
// depends on avz_pkg, avz_sqrt, avz_div
//
// usage: one frame of three raw accelerometer words enters on the input
// channel (valid/ready); one result word per frame leaves on the output
// channel. One frame is processed at a time: scaling and filtering (one
// shared multiplier), the sum of squares, the bit-serial square root with
// its start and finish, a step to pick the branch, then either the serial
// bias division and velocity decay per axis at rest, velocity integration
// per axis otherwise, or neither during the boot wait, and then S_OUT1
// and S_OUT2 to form the output word. The next frame can be accepted while
// out_valid is first high. The result sits in an output register, so a
// waiting result does not block the next frame; a stalled receiver holds
// the next finished frame in its last step until the register is taken.
// Configuration writes go straight into registers; the user must make them
// only while idle, as the block itself does not enforce this. Synchronous
// reset restores the register defaults and clears filter, bias, velocity
// and counters.
module accel_velocity_zupt_estimator (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [17:0] speed_x_mm_s,
  output logic signed [15:0] vel_x_q88,
  output logic signed [15:0] vel_y_q88,
  output logic signed [15:0] vel_z_q88,
  output logic               is_moving,
  output logic               bias_ready,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import avz_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_FILT, S_SQ, S_ROOT, S_DEC, S_DIV, S_DIVW, S_VEL, S_OUT1, S_OUT2
  } state_t;

  state_t state;
  cfg_t   cfg;

  logic signed [FW-1:0] filt [3];
  logic signed [FW-1:0] bias [3];
  logic signed [VW-1:0] vel  [3];
  logic [BcW-1:0] bias_count;
  logic [7:0]     still_count;
  logic [15:0]    frame_count;
  logic signed [15:0] raw [3];
  logic [1:0]     ax;
  logic [32:0]    sum;
  logic           rest;
  logic [BcW-1:0] div_den;
  logic           out_load;

  // shared multiplier operands
  logic signed [18:0] mul_a;
  logic signed [18:0] mul_b;
  logic signed [37:0] prod;
  assign prod = mul_a * mul_b;

  logic signed [FW:0] scaled, fdiff, fnew;
  logic signed [FW:0] lin;
  logic signed [FW+1:0] vsum;
  logic signed [FW:0] lim;

  // sqrt and div units
  logic        sq_start, sq_done;
  logic [15:0] root;
  logic        dv_start, dv_done;
  logic signed [FW:0] dv_num, dv_quo;

  avz_sqrt u_sqrt (.clk(clk), .rst(rst), .start(sq_start),
                   .radicand(sum[32] ? 32'hFFFF_FFFF : sum[31:0]),
                   .done(sq_done), .root(root));
  avz_div u_div (.clk(clk), .rst(rst), .start(dv_start), .num(dv_num),
                 .den(div_den), .done(dv_done), .quo(dv_quo));

  logic [16:0] dev;
  logic        still;
  logic [7:0]  still_next;

  always_comb begin
    mul_a = 19'sd0;
    mul_b = 19'sd0;
    unique case (state)
      S_FILT: begin mul_a = 19'(raw[ax]); mul_b = 19'sd314; end
      S_SQ:   begin mul_a = 19'(filt[ax]); mul_b = 19'(filt[ax]); end
      S_VEL:  begin mul_a = lin; mul_b = 19'sd629; end
      default: ;
    endcase
    scaled = 19'(prod >>> 8);
    fdiff  = scaled - 19'(filt[ax]);
    fnew   = 19'(filt[ax]) + sra_f(fdiff, cfg.lowpass_shift);
    lin    = 19'(filt[ax]) - 19'(bias[ax]);
    vsum   = 20'(vel[ax]) + 20'(prod >>> 16);
    lim    = 19'(cfg.velocity_limit);
    dev    = (17'(root) >= 17'(cfg.gravity_ref)) ? 17'(root) - 17'(cfg.gravity_ref)
                                                 : 17'(cfg.gravity_ref) - 17'(root);
    still  = dev < 17'(cfg.rest_threshold);
    still_next = still ? ((still_count == 8'hFF) ? still_count : still_count + 8'd1)
                       : 8'd0;
    dv_num = 19'(filt[ax]) - 19'(bias[ax]);
  end

  logic signed [17:0] spd;
  logic signed [26:0] spd_full;
  assign spd_full = 27'(vel[0]) * 27'sd1000;
  assign spd = 18'(spd_full >>> 8);

  // output register loads when it is empty or being emptied
  assign in_ready = (state == S_IDLE);
  assign out_load = (state == S_OUT2) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    sq_start <= 1'b0;
    dv_start <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      cfg <= '{lowpass_shift: 4'd2, gravity_ref: 13'd2510, rest_threshold: 12'd205,
               rest_frames_needed: 8'd8, decay_shift: 4'd4, boot_wait_frames: 16'd200,
               velocity_limit: 15'd4000};
      for (int i = 0; i < 3; i++) begin
        filt[i] <= '0; bias[i] <= '0; vel[i] <= '0;
      end
      bias_count <= '0;
      still_count <= '0;
      frame_count <= '0;
      out_valid <= 1'b0;
      ax <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          RegLowpass: cfg.lowpass_shift      <= cfg_data[3:0];
          RegGravity: cfg.gravity_ref        <= cfg_data[12:0];
          RegThresh:  cfg.rest_threshold     <= cfg_data[11:0];
          RegFrames:  cfg.rest_frames_needed <= cfg_data[7:0];
          RegDecay:   cfg.decay_shift        <= cfg_data[3:0];
          RegBoot:    cfg.boot_wait_frames   <= cfg_data[15:0];
          RegLimit:   cfg.velocity_limit     <= cfg_data[14:0];
          default: ;
        endcase
      end
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid && in_ready) begin
          raw[0] <= accel_x; raw[1] <= accel_y; raw[2] <= accel_z;
          if (frame_count != 16'hFFFF) frame_count <= frame_count + 16'd1;
          ax <= 2'd0;
          state <= S_FILT;
        end
        // one axis per cycle through the filter
        S_FILT: begin
          filt[ax] <= FW'(fnew);
          if (ax == 2'd2) begin ax <= 2'd0; sum <= '0; state <= S_SQ; end
          else ax <= ax + 2'd1;
        end
        S_SQ: begin
          sum <= sum + 33'(prod[35:0]);
          if (ax == 2'd2) begin ax <= 2'd0; sq_start <= 1'b1; state <= S_ROOT; end
          else ax <= ax + 2'd1;
        end
        S_ROOT: if (sq_done) begin
          still_count <= still_next;
          rest <= still_next >= cfg.rest_frames_needed;
          state <= S_DEC;
        end
        // decide the branch for this frame
        S_DEC: begin
          ax <= 2'd0;
          if (rest) begin
            if (bias_count < BcW'(BiasLen)) begin
              bias_count <= bias_count + BcW'(1);
              div_den <= bias_count + BcW'(1);
            end else div_den <= BcW'(BiasLen);
            state <= S_DIV;
          end else if (bias_count < BcW'(BiasLen) && frame_count < cfg.boot_wait_frames) begin
            state <= S_OUT1;
          end else begin
            if (bias_count < BcW'(BiasLen)) begin
              for (int i = 0; i < 3; i++) bias[i] <= filt[i];
              bias_count <= BcW'(BiasLen);
            end
            state <= S_VEL;
          end
        end
        S_DIV: begin dv_start <= 1'b1; state <= S_DIVW; end
        S_DIVW: if (dv_done) begin
          bias[ax] <= FW'(19'(bias[ax]) + dv_quo);
          vel[ax] <= vel[ax] - VW'(19'(vel[ax]) >>> cfg.decay_shift);
          if (ax == 2'd2) state <= S_OUT1;
          else begin ax <= ax + 2'd1; state <= S_DIV; end
        end
        S_VEL: begin
          if (vsum > 20'(lim)) vel[ax] <= VW'(lim);
          else if (vsum < -20'(lim)) vel[ax] <= VW'(-lim);
          else vel[ax] <= VW'(vsum);
          if (ax == 2'd2) state <= S_OUT1;
          else ax <= ax + 2'd1;
        end
        S_OUT1: state <= S_OUT2;
        // wait here while the previous word is still held
        S_OUT2: if (out_load) begin
          speed_x_mm_s <= spd;
          vel_x_q88 <= 16'(vel[0]);
          vel_y_q88 <= 16'(vel[1]);
          vel_z_q88 <= 16'(vel[2]);
          is_moving <= !rest;
          bias_ready <= bias_count >= BcW'(BiasLen);
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
